// ===== sv/cid_pkg.sv =====
// Package for the instruction decoder: payload types, opcode constants and
// the opcode / EXT sub-opcode lookup functions. No dependencies.
package cid_pkg;

  // Operation class codes that are not taken from a table entry
  localparam logic [5:0] CLASS_EXT_UNKNOWN = 6'd52;
  localparam logic [5:0] CLASS_UNKNOWN     = 6'd53;
  localparam logic [7:0] EXT_PREFIX        = 8'h1F;

  // Opcodes with their own length or immediate placement
  localparam logic [7:0] OP_05 = 8'h05;
  localparam logic [7:0] OP_60 = 8'h60;
  localparam logic [7:0] OP_64 = 8'h64;
  localparam logic [7:0] OP_68 = 8'h68;
  localparam logic [7:0] OP_69 = 8'h69;

  // Class bases of each opcode group
  localparam logic [5:0] CLASS_GRP_20 = 6'd7;
  localparam logic [5:0] CLASS_GRP_40 = 6'd15;
  localparam logic [5:0] CLASS_GRP_50 = 6'd21;
  localparam logic [5:0] CLASS_GRP_60 = 6'd31;
  localparam logic [5:0] CLASS_OP_68  = 6'd36;
  localparam logic [5:0] CLASS_OP_69  = 6'd37;
  localparam logic [5:0] CLASS_EXT_00 = 6'd38;
  localparam logic [5:0] CLASS_EXT_10 = 6'd44;

  localparam logic [2:0] LEN_1 = 3'd1;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

  // Result of one table lookup
  typedef struct packed {
    logic       hit;
    logic [5:0] op_class;
    logic [2:0] len;
  } dec_t;

  // Stage 2 payload: lookups done, address offset by three
  typedef struct packed {
    dec_t        base_dec;
    dec_t        ext_dec;
    logic        is_ext;
    logic        imm_lo_sel;
    logic [15:0] addr_p3;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic [7:0]  byte_three;
  } s2_t;

  // Final result item
  typedef struct packed {
    logic [5:0]  op_class;
    logic [2:0]  instr_length;
    logic [3:0]  dest_reg;
    logic [3:0]  src_reg;
    logic [15:0] imm_value;
    logic [15:0] branch_target;
    logic        is_unknown;
  } res_t;

  // Base opcode table
  function automatic dec_t base_lookup(input logic [7:0] op);
    dec_t d;
    d.hit      = 1'b1;
    d.op_class = CLASS_UNKNOWN;
    d.len      = LEN_1;
    case (op) inside
      [8'h00:8'h06]: begin
        d.op_class = {3'b000, op[2:0]};
        d.len      = (op == OP_05) ? LEN_3 : LEN_1;
      end
      [8'h20:8'h27]: begin
        d.op_class = CLASS_GRP_20 + {3'b000, op[2:0]};
        d.len      = (op[2:0] == 3'd0 || op[2:0] == 3'd4 || op[2:0] == 3'd5) ? LEN_2 : LEN_4;
      end
      [8'h40:8'h45]: begin
        d.op_class = CLASS_GRP_40 + {3'b000, op[2:0]};
        d.len      = op[0] ? LEN_4 : LEN_2;
      end
      [8'h50:8'h59]: begin
        d.op_class = CLASS_GRP_50 + {2'b00, op[3:0]};
        d.len      = (op[0] && op[3:0] <= 4'd5) ? LEN_4 : LEN_2;
      end
      [OP_60:OP_64]: begin
        d.op_class = CLASS_GRP_60 + {3'b000, op[2:0]};
        d.len      = LEN_3;
      end
      OP_68: begin
        d.op_class = CLASS_OP_68;
        d.len      = LEN_3;
      end
      OP_69: begin
        d.op_class = CLASS_OP_69;
        d.len      = LEN_1;
      end
      default: begin
        d.hit = 1'b0;
      end
    endcase
    return d;
  endfunction

  // EXT sub-opcode table
  function automatic dec_t ext_lookup(input logic [7:0] sub);
    dec_t d;
    d.hit      = 1'b1;
    d.op_class = CLASS_EXT_UNKNOWN;
    d.len      = LEN_2;
    case (sub) inside
      [8'h00:8'h05]: begin
        d.op_class = CLASS_EXT_00 + {3'b000, sub[2:0]};
      end
      [8'h10:8'h17]: begin
        d.op_class = CLASS_EXT_10 + {3'b000, sub[2:0]};
        d.len      = sub[0] ? LEN_2 : LEN_4;
      end
      default: begin
        d.hit = 1'b0;
      end
    endcase
    return d;
  endfunction

endpackage

// ===== sv/cid_lookup.sv =====
// Stage 2 of the decoder: table lookups on the opcode and sub-opcode, and
// the address-plus-three add. Depends on cid_pkg.
module cid_lookup (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [15:0]         addr_i,
  input  logic [7:0]          byte_zero_i,
  input  logic [7:0]          byte_one_i,
  input  logic [7:0]          byte_two_i,
  input  logic [7:0]          byte_three_i,
  output logic                valid_o,
  input  logic                ready_i,
  output cid_pkg::s2_t        data_o
);

  logic         valid_q;
  cid_pkg::s2_t data_q, data_d;

  // Stage moves when empty or when downstream takes the item
  assign ready_o = !valid_q || ready_i;

  // Lookups and address offset
  always_comb begin
    data_d.base_dec   = cid_pkg::base_lookup(byte_zero_i);
    data_d.ext_dec    = cid_pkg::ext_lookup(byte_one_i);
    data_d.is_ext     = (byte_zero_i == cid_pkg::EXT_PREFIX);
    data_d.imm_lo_sel = byte_zero_i inside {cid_pkg::OP_05, cid_pkg::OP_68,
                                            [cid_pkg::OP_60:cid_pkg::OP_64]};
    data_d.addr_p3    = addr_i + 16'd3;
    data_d.byte_one   = byte_one_i;
    data_d.byte_two   = byte_two_i;
    data_d.byte_three = byte_three_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/cid_resolve.sv =====
// Stage 3 of the decoder: picks class, length and immediate, adds the
// branch offset, and holds the result item. Depends on cid_pkg.
module cid_resolve (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  cid_pkg::s2_t        data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output cid_pkg::res_t       res_o
);

  logic          valid_q;
  cid_pkg::res_t res_q, res_d;
  logic [15:0]   imm_lo;
  logic [15:0]   imm_hi;

  assign ready_o = !valid_q || ready_i;

  // Final field selection
  always_comb begin
    imm_lo = {data_i.byte_two, data_i.byte_one};
    imm_hi = {data_i.byte_three, data_i.byte_two};
    if (data_i.is_ext) begin
      res_d.op_class     = data_i.ext_dec.hit ? data_i.ext_dec.op_class
                                              : cid_pkg::CLASS_EXT_UNKNOWN;
      res_d.instr_length = data_i.ext_dec.hit ? data_i.ext_dec.len : cid_pkg::LEN_2;
      res_d.is_unknown   = !data_i.ext_dec.hit;
    end else begin
      res_d.op_class     = data_i.base_dec.hit ? data_i.base_dec.op_class
                                               : cid_pkg::CLASS_UNKNOWN;
      res_d.instr_length = data_i.base_dec.hit ? data_i.base_dec.len : cid_pkg::LEN_1;
      res_d.is_unknown   = !data_i.base_dec.hit;
    end
    res_d.dest_reg      = data_i.byte_one[7:4];
    res_d.src_reg       = data_i.byte_one[3:0];
    res_d.imm_value     = data_i.imm_lo_sel ? imm_lo : imm_hi;
    res_d.branch_target = data_i.addr_p3 + imm_lo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== sv/custom_isa_instruction_decoder.sv =====
// Top level of the instruction decoder: input register stage, lookup and
// resolve stages. Depends on cid_pkg, cid_lookup and cid_resolve.
//
//   channel | handshake                  | payload
//   --------+----------------------------+------------------------------------
//   in      | in_valid_i / in_ready_o    | instr_address_i, byte_zero_i..three_i
//   out     | out_valid_o / out_ready_i  | op_class_o .. is_unknown_o
//
// One item per cycle while the output is not stalled; each item passes the input
// register, lookup stage and resolve/output stage in turn.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall at the output backs up stage by stage; empty stages still fill,
// so nothing is dropped or repeated.
module custom_isa_instruction_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] instr_address_i,
  input  logic [7:0]  byte_zero_i,
  input  logic [7:0]  byte_one_i,
  input  logic [7:0]  byte_two_i,
  input  logic [7:0]  byte_three_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  op_class_o,
  output logic [2:0]  instr_length_o,
  output logic [3:0]  dest_reg_o,
  output logic [3:0]  src_reg_o,
  output logic [15:0] imm_value_o,
  output logic [15:0] branch_target_o,
  output logic        is_unknown_o
);

  logic          s1_valid_q;
  logic [15:0]   s1_addr_q;
  logic [7:0]    s1_b0_q, s1_b1_q, s1_b2_q, s1_b3_q;
  logic          s2_ready;
  logic          s2_valid;
  cid_pkg::s2_t  s2_data;
  logic          s3_ready;
  cid_pkg::res_t res;

  // Input register stage
  assign in_ready_o = !s1_valid_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_addr_q <= instr_address_i;
      s1_b0_q   <= byte_zero_i;
      s1_b1_q   <= byte_one_i;
      s1_b2_q   <= byte_two_i;
      s1_b3_q   <= byte_three_i;
    end
  end

  // Table lookups
  cid_lookup u_lookup (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s1_valid_q),
    .ready_o      (s2_ready),
    .addr_i       (s1_addr_q),
    .byte_zero_i  (s1_b0_q),
    .byte_one_i   (s1_b1_q),
    .byte_two_i   (s1_b2_q),
    .byte_three_i (s1_b3_q),
    .valid_o      (s2_valid),
    .ready_i      (s3_ready),
    .data_o       (s2_data)
  );

  // Field selection and output register
  cid_resolve u_resolve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .data_i  (s2_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res)
  );

  assign op_class_o      = res.op_class;
  assign instr_length_o  = res.instr_length;
  assign dest_reg_o      = res.dest_reg;
  assign src_reg_o       = res.src_reg;
  assign imm_value_o     = res.imm_value;
  assign branch_target_o = res.branch_target;
  assign is_unknown_o    = res.is_unknown;

endmodule

// ===== sv/cid_checker.sv =====
// Port-level checks for the instruction decoder, bound to the top level.
// Depends on custom_isa_instruction_decoder and cid_pkg.
module cid_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  op_class_o,
  input logic [2:0]  instr_length_o,
  input logic        is_unknown_o
);

  // A stalled result item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // With the output draining, the input is never held off
  a_in_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output ready");

  // Unknown flag matches the two unknown classes
  a_unknown_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_unknown_o ==
      (op_class_o == cid_pkg::CLASS_EXT_UNKNOWN || op_class_o == cid_pkg::CLASS_UNKNOWN)))
    else $error("unknown flag and class disagree");

  // Unknown opcodes are one byte, unknown EXT two
  a_unknown_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_unknown_o |->
      ((op_class_o == cid_pkg::CLASS_UNKNOWN && instr_length_o == cid_pkg::LEN_1) ||
       (op_class_o == cid_pkg::CLASS_EXT_UNKNOWN && instr_length_o == cid_pkg::LEN_2)))
    else $error("bad length for unknown instruction");

  // Length always in 1..4
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (instr_length_o >= cid_pkg::LEN_1 && instr_length_o <= cid_pkg::LEN_4))
    else $error("instruction length out of range");

endmodule

bind custom_isa_instruction_decoder cid_checker u_cid_checker (.*);
